### rtl/ffxp_pkg.sv
// ----------------------------------------------------------------------------
// ffxp_pkg
// Shared types and constants of the frame fragmenter with XOR parity.
// ----------------------------------------------------------------------------
package ffxp_pkg;

  localparam int PARITY_DEPTH = 2048;
  localparam int PAR_AW       = $clog2(PARITY_DEPTH);
  localparam int FRAG_LIMIT   = (PARITY_DEPTH < 2048) ? PARITY_DEPTH : 2048;
  localparam int REG_W        = 12;
  localparam int DIV_W        = 25;

  localparam logic [15:0] MAX_COUNT = 16'hFFFF;
  localparam logic [11:0] FRAG_RESET = 12'd1400;

  typedef enum logic [0:0] {
    REG_MAX_FRAG = 1'b0,
    REG_FEC_EN   = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_DATA   = 1'b0,
    MODE_PARITY = 1'b1
  } item_mode_t;

  typedef struct packed {
    item_mode_t  mode;
    logic [7:0]  data;
    logic [23:0] size;
  } q_item_t;

  typedef struct packed {
    logic [11:0] frag_size;
    logic        fec_enable;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [11:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        role;
    logic [15:0] frag_idx;
    logic [15:0] frag_cnt;
    logic [23:0] frag_base;
    logic [10:0] byte_in_fragment;
    logic        last_in_fragment;
    logic        last_in_frame;
    logic        frame_dropped;
    logic        parity_none;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DATA,
    S_WRITE,
    S_PREAD,
    S_EMIT
  } back_state_t;

endpackage

### rtl/ffxp_in_if.sv
// ----------------------------------------------------------------------------
// ffxp_in_if
// Input channel: one payload byte or parity request per item.
// ----------------------------------------------------------------------------
interface ffxp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  payload_byte;
  logic [23:0] frame_size;

  modport source(output valid, mode, payload_byte, frame_size, input ready);
  modport sink(input valid, mode, payload_byte, frame_size, output ready);
endinterface

### rtl/ffxp_out_if.sv
// ----------------------------------------------------------------------------
// ffxp_out_if
// Result channel: one labelled data or parity byte per item.
// ----------------------------------------------------------------------------
interface ffxp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic        role;
  logic [15:0] frag_idx;
  logic [15:0] frag_cnt;
  logic [23:0] frag_base;
  logic [10:0] byte_in_fragment;
  logic        last_in_fragment;
  logic        last_in_frame;
  logic        frame_dropped;
  logic        parity_none;

  modport source(output valid, byte_value, role, frag_idx, frag_cnt,
                 frag_base, byte_in_fragment, last_in_fragment, last_in_frame,
                 frame_dropped, parity_none, input ready);
  modport sink(input valid, byte_value, role, frag_idx, frag_cnt,
               frag_base, byte_in_fragment, last_in_fragment, last_in_frame,
               frame_dropped, parity_none, output ready);
endinterface

### rtl/ffxp_front.sv
// ----------------------------------------------------------------------------
// ffxp_front
// Accepts items, tags them as data or parity request, normalizes the frame
// size and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ffxp_front (
  input  logic             clk,
  input  logic             rst,
  ffxp_in_if.sink          payload,
  output ffxp_pkg::q_item_t q_item,
  output logic             q_valid,
  input  logic             q_pop
);
  import ffxp_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  q_item_t            slots [QDEPTH];
  q_item_t            incoming;
  logic [QAW-1:0]     wr_ptr;
  logic [QAW-1:0]     rd_ptr;
  logic [QAW:0]       fill;
  logic               push;

  assign payload.ready = (fill != (QAW+1)'(QDEPTH));
  assign push          = payload.valid && payload.ready;
  assign q_valid       = (fill != '0);
  assign q_item        = slots[rd_ptr];

  // A frame size of zero behaves as a one-byte frame.
  always_comb begin
    incoming.mode = item_mode_t'(payload.mode);
    incoming.data = payload.payload_byte;
    incoming.size = (payload.frame_size == 24'd0) ? 24'd1 : payload.frame_size;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end
  end

endmodule

### rtl/ffxp_div.sv
// ----------------------------------------------------------------------------
// ffxp_div
// Restoring divider, one quotient bit per cycle, used once per frame to
// find the fragment count.
// ----------------------------------------------------------------------------
module ffxp_div (
  input  logic              clk,
  input  logic              rst,
  input  ffxp_pkg::div_req_t req,
  output ffxp_pkg::div_rsp_t rsp
);
  import ffxp_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] num;
  logic [11:0]      rem;
  logic [11:0]      dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [12:0]      trial;
  logic             qbit;

  assign trial = {rem, num[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        // The dividend shifts out at the top while quotient bits enter below.
        num <= {num[DIV_W-2:0], qbit};
        rem <= qbit ? 12'(trial - {1'b0, dvs}) : trial[11:0];
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/ffxp_back.sv
// ----------------------------------------------------------------------------
// ffxp_back
// Sequencer that labels data bytes, folds them into the parity memory and
// reads parity back out, with a result register toward the output.
// ----------------------------------------------------------------------------
module ffxp_back (
  input  logic               clk,
  input  logic               rst,
  input  ffxp_pkg::cfg_t     cfg,
  input  ffxp_pkg::q_item_t  q_item,
  input  logic               q_valid,
  output logic               q_pop,
  output ffxp_pkg::div_req_t div_req,
  input  ffxp_pkg::div_rsp_t div_rsp,
  ffxp_out_if.source         result
);
  import ffxp_pkg::*;

  back_state_t       state, state_next;
  q_item_t           item, item_next;
  result_t           res, res_next;
  result_t           out_data;
  logic              out_valid, out_valid_next;
  logic              out_load;

  logic [23:0]       frame_position, frame_position_next;
  logic [15:0]       current_fragment, current_fragment_next;
  logic [10:0]       pos, pos_next;
  logic [15:0]       frag_count, frag_count_next;
  logic [11:0]       parity_length, parity_length_next;
  logic [10:0]       read_ptr, read_ptr_next;
  logic              parity_pending, parity_pending_next;
  logic [PAR_AW-1:0] wr_addr, wr_addr_next;
  logic              wr_fresh, wr_fresh_next;

  logic [7:0]        store [PARITY_DEPTH];
  logic [PAR_AW-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  logic              last_frame;
  logic              last_frag;
  logic              pos_fits;
  logic              fresh;
  logic [11:0]       pos_plus;
  logic [11:0]       plen_upd;
  logic              p_last;

  assign pos_plus   = {1'b0, pos} + 12'd1;
  assign last_frame = ({1'b0, frame_position} + 25'd1) >= {1'b0, item.size};
  assign last_frag  = last_frame || (pos_plus >= cfg.frag_size);
  assign pos_fits   = (17'(pos) < 17'(PARITY_DEPTH));
  assign fresh      = (current_fragment == 16'd0) || ({1'b0, pos} >= parity_length);
  assign plen_upd   = (pos_fits && fresh && (pos_plus > parity_length)) ? pos_plus
                                                                       : parity_length;
  assign p_last     = ({1'b0, read_ptr} + 12'd1) >= parity_length;
  assign mem_raddr  = (state == S_IDLE) ? PAR_AW'(read_ptr) : PAR_AW'(pos);
  assign mem_wdata  = wr_fresh ? item.data : (mem_rdata ^ item.data);

  // Parity memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_addr] <= mem_wdata;
    end
    mem_rdata <= store[mem_raddr];
  end

  always_comb begin
    state_next            = state;
    item_next             = item;
    res_next              = res;
    frame_position_next   = frame_position;
    current_fragment_next = current_fragment;
    pos_next              = pos;
    frag_count_next       = frag_count;
    parity_length_next    = parity_length;
    read_ptr_next         = read_ptr;
    parity_pending_next   = parity_pending;
    wr_addr_next          = wr_addr;
    wr_fresh_next         = wr_fresh;
    q_pop                 = 1'b0;
    mem_we                = 1'b0;
    out_load              = 1'b0;
    div_req.start         = 1'b0;
    div_req.dividend      = {1'b0, q_item.size} + DIV_W'(cfg.frag_size) - DIV_W'(1);
    div_req.divisor       = cfg.frag_size;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_next = q_item;
          if (q_item.mode == MODE_PARITY) begin
            if (parity_pending) begin
              state_next = S_PREAD;
            end else begin
              res_next             = '0;
              res_next.parity_none = 1'b1;
              state_next           = S_EMIT;
            end
          end else begin
            // Any data byte discards parity that was not read out.
            parity_pending_next = 1'b0;
            read_ptr_next       = '0;
            if (frame_position == 24'd0) begin
              div_req.start         = 1'b1;
              current_fragment_next = '0;
              pos_next              = '0;
              parity_length_next    = '0;
              state_next            = S_DIV;
            end else begin
              state_next = S_DATA;
            end
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          // A count of zero marks a frame with too many fragments.
          frag_count_next = (div_rsp.quotient > DIV_W'(MAX_COUNT)) ? 16'd0
                                                                   : div_rsp.quotient[15:0];
          state_next      = S_DATA;
        end
      end

      S_DATA: begin
        res_next               = '0;
        res_next.byte_value    = item.data;
        res_next.last_in_frame = last_frame;
        if (frag_count == 16'd0) begin
          res_next.frame_dropped = 1'b1;
          frame_position_next    = last_frame ? 24'd0 : frame_position + 24'd1;
          state_next             = S_EMIT;
        end else begin
          res_next.frag_idx         = current_fragment;
          res_next.frag_cnt         = frag_count;
          res_next.frag_base        = frame_position - 24'(pos);
          res_next.byte_in_fragment = pos;
          res_next.last_in_fragment = last_frag;
          wr_addr_next              = PAR_AW'(pos);
          wr_fresh_next             = fresh;
          parity_length_next        = plen_upd;
          if (last_frame) begin
            frame_position_next   = '0;
            pos_next              = '0;
            current_fragment_next = '0;
            if (cfg.fec_enable && (frag_count > 16'd1) && (plen_upd != 12'd0)) begin
              parity_pending_next = 1'b1;
              read_ptr_next       = '0;
            end
          end else begin
            frame_position_next = frame_position + 24'd1;
            if (last_frag) begin
              pos_next              = '0;
              current_fragment_next = current_fragment + 16'd1;
            end else begin
              pos_next = pos + 11'd1;
            end
          end
          state_next = pos_fits ? S_WRITE : S_EMIT;
        end
      end

      S_WRITE: begin
        mem_we     = 1'b1;
        state_next = S_EMIT;
      end

      S_PREAD: begin
        res_next                  = '0;
        res_next.byte_value       = mem_rdata;
        res_next.role             = 1'b1;
        res_next.frag_cnt         = frag_count;
        res_next.byte_in_fragment = read_ptr;
        res_next.last_in_fragment = p_last;
        res_next.last_in_frame    = p_last;
        if (p_last) begin
          parity_pending_next = 1'b0;
          read_ptr_next       = '0;
        end else begin
          read_ptr_next = read_ptr + 11'd1;
        end
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      frame_position   <= '0;
      current_fragment <= '0;
      pos              <= '0;
      frag_count       <= '0;
      parity_length    <= '0;
      read_ptr         <= '0;
      parity_pending   <= 1'b0;
    end else begin
      state            <= state_next;
      out_valid        <= out_valid_next;
      frame_position   <= frame_position_next;
      current_fragment <= current_fragment_next;
      pos              <= pos_next;
      frag_count       <= frag_count_next;
      parity_length    <= parity_length_next;
      read_ptr         <= read_ptr_next;
      parity_pending   <= parity_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    res      <= res_next;
    wr_addr  <= wr_addr_next;
    wr_fresh <= wr_fresh_next;
    if (out_load) begin
      out_data <= res;
    end
  end

  assign result.valid            = out_valid;
  assign result.byte_value       = out_data.byte_value;
  assign result.role             = out_data.role;
  assign result.frag_idx         = out_data.frag_idx;
  assign result.frag_cnt         = out_data.frag_cnt;
  assign result.frag_base        = out_data.frag_base;
  assign result.byte_in_fragment = out_data.byte_in_fragment;
  assign result.last_in_fragment = out_data.last_in_fragment;
  assign result.last_in_frame    = out_data.last_in_frame;
  assign result.frame_dropped    = out_data.frame_dropped;
  assign result.parity_none      = out_data.parity_none;

endmodule

### rtl/frame_fragmenter_xor_parity.sv
// ----------------------------------------------------------------------------
// frame_fragmenter_xor_parity
// Splits frame payload bytes into labelled fragments and builds an XOR
// parity fragment across them.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake            Content
//  payload   in   valid/ready          mode, payload_byte, frame_size
//  result    out  valid/ready          labelled data or parity byte
//  wr_*      in   wr_en, no back-pressure   max_fragment_payload, fec_enable
//
// A data byte runs IDLE, DATA, WRITE, EMIT in the sequencer, without WRITE in a
// dropped frame; the first byte of a frame adds DIV for the 25-step bit-serial
// divider of the fragment count. A parity read runs IDLE, PREAD, EMIT (no PREAD
// when none is pending). Data bytes pass through the parity memory as a read
// followed by a write. rst is synchronous and clears all control state; the
// parity memory is not cleared. A two-entry queue keeps taking items while a
// result waits on a stalled output.
// ----------------------------------------------------------------------------
module frame_fragmenter_xor_parity (
  input  logic               clk,
  input  logic               rst,
  ffxp_in_if.sink            payload,
  ffxp_out_if.source         result,
  input  logic               wr_en,
  input  ffxp_pkg::reg_idx_t wr_index,
  input  logic [11:0]        wr_data
);
  import ffxp_pkg::*;

  logic [REG_W-1:0] max_frag;
  logic             fec_en;
  cfg_t             cfg;
  q_item_t          q_item;
  logic             q_valid;
  logic             q_pop;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frag <= FRAG_RESET;
      fec_en   <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAX_FRAG: max_frag <= wr_data;
        REG_FEC_EN:   fec_en   <= wr_data[0];
        default:      ;
      endcase
    end
  end

  // Zero acts as one, oversize values saturate to the parity memory size.
  always_comb begin
    if (max_frag == '0) begin
      cfg.frag_size = 12'd1;
    end else if (max_frag > 12'(FRAG_LIMIT)) begin
      cfg.frag_size = 12'(FRAG_LIMIT);
    end else begin
      cfg.frag_size = max_frag;
    end
    cfg.fec_enable = fec_en;
  end

  ffxp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .payload (payload),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  ffxp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ffxp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .result  (result)
  );

endmodule

### rtl/ffxp_checker.sv
// ----------------------------------------------------------------------------
// ffxp_checker
// Port-level checks on the result channel of the fragmenter.
// ----------------------------------------------------------------------------
module ffxp_checker (
  input logic        clk,
  input logic        rst,
  input logic        r_valid,
  input logic        r_ready,
  input logic [7:0]  r_byte_value,
  input logic        r_role,
  input logic [15:0] r_frag_idx,
  input logic [15:0] r_frag_cnt,
  input logic [23:0] r_frag_base,
  input logic        r_last_in_fragment,
  input logic        r_last_in_frame,
  input logic        r_frame_dropped,
  input logic        r_parity_none
);

  // No result may appear in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst && $past(rst) |-> !r_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_byte_value) && $stable(r_role)
                            && $stable(r_frag_base))
    else $error("stalled result changed");

  a_parity_fields: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_role |-> r_frag_idx == 16'd0 && r_frag_base == 24'd0
                          && !r_frame_dropped && !r_parity_none
                          && (r_last_in_fragment == r_last_in_frame))
    else $error("parity item carries data labels");

  a_dropped_fields: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_frame_dropped |-> !r_role && r_frag_cnt == 16'd0
                                   && r_frag_idx == 16'd0 && !r_last_in_fragment)
    else $error("dropped frame item carries fragment labels");

  a_none_fields: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_parity_none |-> r_byte_value == 8'd0 && !r_role && !r_last_in_frame)
    else $error("empty parity answer carries data");

endmodule

bind frame_fragmenter_xor_parity ffxp_checker u_checker (
  .clk                (clk),
  .rst                (rst),
  .r_valid            (result.valid),
  .r_ready            (result.ready),
  .r_byte_value       (result.byte_value),
  .r_role             (result.role),
  .r_frag_idx         (result.frag_idx),
  .r_frag_cnt         (result.frag_cnt),
  .r_frag_base        (result.frag_base),
  .r_last_in_fragment (result.last_in_fragment),
  .r_last_in_frame    (result.last_in_frame),
  .r_frame_dropped    (result.frame_dropped),
  .r_parity_none      (result.parity_none)
);
